[rtl/preemptive_priority_scheduler_defines.svh]
// Assertion macros for the preemptive priority scheduler.
// Included by modules that carry concurrent assertions; no dependencies.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PPSCH_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppsch: assertion failed");

// next-cycle implication, disabled during reset
`define PPSCH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppsch: assertion failed");

`endif

[rtl/ppsch_pkg.sv]
// Shared types and constants for the preemptive priority scheduler.
// No dependencies; used by the cell, the controller and the top level.
package ppsch_pkg;

    localparam int unsigned ArrW  = 16;
    localparam int unsigned BurW  = 16;
    localparam int unsigned UrgW  = 8;
    localparam int unsigned TimeW = 24;
    localparam int unsigned AbW   = 17;
    localparam int unsigned OutIdxW = 4;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SWEEP,
        S_APPLY,
        S_EMIT
    } t_state;

    // best candidate and earliest future arrival, passed from cell to cell
    typedef struct packed {
        logic            found;
        logic [UrgW-1:0] urg;
        logic [BurW-1:0] rem;
        logic [ArrW-1:0] arr;
        logic [AbW-1:0]  ab;
        logic            nfound;
        logic [ArrW-1:0] narr;
    } t_token;

    // broadcast from controller to all cells
    typedef struct packed {
        logic            load;
        logic            apply;
        logic            finish;
        logic            clear;
        logic [BurW-1:0] delta;
        logic [ArrW-1:0] arrival;
        logic [BurW-1:0] burst;
        logic [UrgW-1:0] urgency;
    } t_cmd;

endpackage

[rtl/ppsch_cell.sv]
// One process slot of the scheduler chain: holds a process and merges it into the token.
// Depends on ppsch_pkg.
module ppsch_cell
    import ppsch_pkg::*;
#(
    parameter int unsigned IdxW    = 4,
    parameter int unsigned CellIdx = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [TimeW-1:0] i_time,
    input  t_cmd             i_cmd,
    input  logic [IdxW-1:0]  i_sel_idx,
    input  t_token           i_tok,
    input  logic [IdxW-1:0]  i_tok_idx,
    output t_token           o_tok,
    output logic [IdxW-1:0]  o_tok_idx
);

    logic            r_loaded;
    logic            r_done;
    logic [ArrW-1:0] r_arr;
    logic [BurW-1:0] r_rem;
    logic [AbW-1:0]  r_ab;
    logic [UrgW-1:0] r_urg;
    t_token          r_tok;
    logic [IdxW-1:0] r_tok_idx;

    logic            sel;
    logic            live;
    logic            arrived;
    logic            better;
    logic            nbetter;
    logic [BurW-1:0] bfix;
    t_token          n_tok;
    logic [IdxW-1:0] n_tok_idx;

    assign sel     = (i_sel_idx == IdxW'(CellIdx));
    assign live    = r_loaded && !r_done;
    assign arrived = (TimeW'(r_arr) <= i_time);
    assign better  = live && arrived && (!i_tok.found || (r_urg < i_tok.urg));
    assign nbetter = live && !arrived && (!i_tok.nfound || (r_arr < i_tok.narr));
    assign bfix    = (i_cmd.burst == '0) ? BurW'(1) : i_cmd.burst;

    always_comb begin
        n_tok     = i_tok;
        n_tok_idx = i_tok_idx;
        if (better) begin
            n_tok.found = 1'b1;
            n_tok.urg   = r_urg;
            n_tok.rem   = r_rem;
            n_tok.arr   = r_arr;
            n_tok.ab    = r_ab;
            n_tok_idx   = IdxW'(CellIdx);
        end
        if (nbetter) begin
            n_tok.nfound = 1'b1;
            n_tok.narr   = r_arr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= 1'b0;
            r_done   <= 1'b0;
        end else if (i_cmd.clear) begin
            r_loaded <= 1'b0;
            r_done   <= 1'b0;
        end else if (i_cmd.load && sel) begin
            r_loaded <= 1'b1;
            r_done   <= 1'b0;
        end else if (i_cmd.apply && i_cmd.finish && sel) begin
            r_done   <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok     <= n_tok;
        r_tok_idx <= n_tok_idx;
        if (i_cmd.load && sel) begin
            r_arr <= i_cmd.arrival;
            r_rem <= bfix;
            r_ab  <= AbW'(i_cmd.arrival) + AbW'(bfix);
            r_urg <= i_cmd.urgency;
        end else if (i_cmd.apply && sel) begin
            r_rem <= r_rem - i_cmd.delta;
        end
    end

    assign o_tok     = r_tok;
    assign o_tok_idx = r_tok_idx;

endmodule

[rtl/ppsch_ctrl.sv]
// Load sequencer, schedule clock and result register for the scheduler.
// Depends on ppsch_pkg and preemptive_priority_scheduler_defines.svh.
`include "preemptive_priority_scheduler_defines.svh"

module ppsch_ctrl
    import ppsch_pkg::*;
#(
    parameter int unsigned MaxProc = 16,
    parameter int unsigned IdxW    = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [ArrW-1:0]     i_arrival_time,
    input  logic [BurW-1:0]     i_burst_length,
    input  logic [UrgW-1:0]     i_urgency,
    input  logic                i_last_process,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [OutIdxW-1:0]  o_process_index,
    output logic [TimeW-1:0]    o_completion_time,
    output logic [TimeW-1:0]    o_turnaround_time,
    output logic [TimeW-1:0]    o_waiting_time,
    output logic                o_last_result,
    input  t_token              i_tok,
    input  logic [IdxW-1:0]     i_tok_idx,
    output logic [TimeW-1:0]    o_time,
    output t_cmd                o_cmd,
    output logic [IdxW-1:0]     o_sel_idx
);

    localparam int unsigned CntW = $clog2(MaxProc + 1);
    localparam int unsigned SwW  = $clog2(MaxProc);

    t_state           r_state, n_state;
    logic [CntW-1:0]  r_count, n_count;
    logic [CntW-1:0]  r_done_cnt, n_done_cnt;
    logic [SwW-1:0]   r_sweep, n_sweep;
    logic [TimeW-1:0] r_time, n_time;
    logic             r_out_valid, n_out_valid;

    logic [IdxW-1:0]  r_res_idx;
    logic [ArrW-1:0]  r_res_arr;
    logic [AbW-1:0]   r_res_ab;
    logic [OutIdxW-1:0] r_o_idx;
    logic [TimeW-1:0] r_o_comp;
    logic [TimeW-1:0] r_o_tat;
    logic [TimeW-1:0] r_o_wait;
    logic             r_o_last;

    logic             accept;
    logic [CntW-1:0]  count_inc;
    logic [TimeW-1:0] sum;
    logic [TimeW-1:0] gap;
    logic             fin;
    logic             capture;
    logic             emit_go;
    logic             emit_last;

    assign accept    = i_in_valid && o_in_ready;
    assign count_inc = r_count + CntW'(1);
    assign sum       = r_time + TimeW'(i_tok.rem);
    assign gap       = TimeW'(i_tok.narr) - r_time;
    assign fin       = !i_tok.nfound || (sum <= TimeW'(i_tok.narr));
    assign emit_go   = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    assign emit_last = emit_go && (r_done_cnt == r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_done_cnt  = r_done_cnt;
        n_sweep     = r_sweep;
        n_time      = r_time;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        capture     = 1'b0;
        o_sel_idx   = i_tok_idx;
        o_cmd       = '0;
        o_cmd.arrival = i_arrival_time;
        o_cmd.burst   = i_burst_length;
        o_cmd.urgency = i_urgency;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                o_sel_idx  = r_count[IdxW-1:0];
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_count    = count_inc;
                    if (i_last_process || (count_inc == CntW'(MaxProc))) begin
                        n_sweep = '0;
                        n_state = S_SWEEP;
                    end
                end
            end
            S_SWEEP: begin
                n_sweep = r_sweep + SwW'(1);
                if (r_sweep == SwW'(MaxProc - 1)) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_sweep = '0;
                if (i_tok.found) begin
                    o_cmd.apply  = 1'b1;
                    o_cmd.finish = fin;
                    o_cmd.delta  = fin ? i_tok.rem : gap[BurW-1:0];
                    n_time       = fin ? sum : TimeW'(i_tok.narr);
                    if (fin) begin
                        capture    = 1'b1;
                        n_done_cnt = r_done_cnt + CntW'(1);
                        n_state    = S_EMIT;
                    end else begin
                        n_state = S_SWEEP;
                    end
                end else begin
                    n_time  = TimeW'(i_tok.narr);
                    n_state = S_SWEEP;
                end
            end
            S_EMIT: begin
                if (emit_go) begin
                    n_out_valid = 1'b1;
                    if (emit_last) begin
                        o_cmd.clear = 1'b1;
                        n_count     = '0;
                        n_done_cnt  = '0;
                        n_time      = '0;
                        n_state     = S_LOAD;
                    end else begin
                        n_sweep = '0;
                        n_state = S_SWEEP;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_done_cnt  <= '0;
            r_sweep     <= '0;
            r_time      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_done_cnt  <= n_done_cnt;
            r_sweep     <= n_sweep;
            r_time      <= n_time;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_res_idx <= i_tok_idx;
            r_res_arr <= i_tok.arr;
            r_res_ab  <= i_tok.ab;
        end
        if (emit_go) begin
            r_o_idx  <= OutIdxW'(r_res_idx);
            r_o_comp <= r_time;
            r_o_tat  <= r_time - TimeW'(r_res_arr);
            r_o_wait <= r_time - TimeW'(r_res_ab);
            r_o_last <= (r_done_cnt == r_count);
        end
    end

    assign o_time            = r_time;
    assign o_out_valid       = r_out_valid;
    assign o_process_index   = r_o_idx;
    assign o_completion_time = r_o_comp;
    assign o_turnaround_time = r_o_tat;
    assign o_waiting_time    = r_o_wait;
    assign o_last_result     = r_o_last;

    `PPSCH_ASSERT(a_done_le_count, i_clk, i_rst_n, 1'b1, r_done_cnt <= r_count)
    `PPSCH_ASSERT(a_idle_has_next, i_clk, i_rst_n, (r_state == S_APPLY) && !i_tok.found, i_tok.nfound)
    `PPSCH_ASSERT_NEXT(a_time_monotonic, i_clk, i_rst_n, r_state == S_APPLY, r_time >= $past(r_time))
    `PPSCH_ASSERT_NEXT(a_set_clears, i_clk, i_rst_n, emit_last, (r_state == S_LOAD) && (r_count == '0) && (r_time == '0))

endmodule

[rtl/preemptive_priority_scheduler.sv]
// Preemptive priority scheduler: loads up to MAX_PROCESSES processes, then reports completions.
// Input channel: i_in_valid / o_in_ready with arrival time, burst length, urgency and a last mark.
// One transaction is taken per cycle while loading; the transaction marked last, or the one
// that fills the final slot, starts the run. No input is taken during the run.
// Output channel: o_out_valid / i_out_ready, one transaction per process in completion order,
// carrying index, completion, turnaround and waiting time; the final one has o_last_result set.
// The run steps from one scheduling event (arrival or completion) to the next. For each event
// the token passes along the cell chain in the sweep state and is then applied in the apply
// state, and a completion then loads the output register in the emit state. A set of N
// processes has at most 2N events.
// A stalled receiver holds the result register; the run goes on to the next completion
// and waits there until the held result is taken.
// Loading of the next set begins while the final result still waits on the output.
// Reset (synchronous, active low) empties all slots and returns to loading.
// Depends on ppsch_pkg, ppsch_cell and ppsch_ctrl.
module preemptive_priority_scheduler
    import ppsch_pkg::*;
#(
    parameter int unsigned MAX_PROCESSES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [ArrW-1:0]    i_arrival_time,
    input  logic [BurW-1:0]    i_burst_length,
    input  logic [UrgW-1:0]    i_urgency,
    input  logic               i_last_process,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [OutIdxW-1:0] o_process_index,
    output logic [TimeW-1:0]   o_completion_time,
    output logic [TimeW-1:0]   o_turnaround_time,
    output logic [TimeW-1:0]   o_waiting_time,
    output logic               o_last_result
);

    localparam int unsigned IdxW = $clog2(MAX_PROCESSES);

    t_token          tok     [0:MAX_PROCESSES];
    logic [IdxW-1:0] tok_idx [0:MAX_PROCESSES];
    logic [TimeW-1:0] cur_time;
    t_cmd            cmd;
    logic [IdxW-1:0] sel_idx;

    assign tok[0]     = '0;
    assign tok_idx[0] = '0;

    for (genvar k = 0; k < MAX_PROCESSES; k++) begin : g_cell
        ppsch_cell #(
            .IdxW    (IdxW),
            .CellIdx (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_time    (cur_time),
            .i_cmd     (cmd),
            .i_sel_idx (sel_idx),
            .i_tok     (tok[k]),
            .i_tok_idx (tok_idx[k]),
            .o_tok     (tok[k+1]),
            .o_tok_idx (tok_idx[k+1])
        );
    end

    ppsch_ctrl #(
        .MaxProc (MAX_PROCESSES),
        .IdxW    (IdxW)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_arrival_time    (i_arrival_time),
        .i_burst_length    (i_burst_length),
        .i_urgency         (i_urgency),
        .i_last_process    (i_last_process),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_process_index   (o_process_index),
        .o_completion_time (o_completion_time),
        .o_turnaround_time (o_turnaround_time),
        .o_waiting_time    (o_waiting_time),
        .o_last_result     (o_last_result),
        .i_tok             (tok[MAX_PROCESSES]),
        .i_tok_idx         (tok_idx[MAX_PROCESSES]),
        .o_time            (cur_time),
        .o_cmd             (cmd),
        .o_sel_idx         (sel_idx)
    );

endmodule
